[hdl/wsfh_pkg.sv]
// ============================================================================
// wsfh_pkg
// Types and constants shared by the WebSocket frame header parser.
// ============================================================================
package wsfh_pkg;

	// Parse phases of one frame header.
	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXT16   = 3'd2,
		PH_EXT64   = 3'd3,
		PH_KEY     = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	// Length codes in the second header byte that call for an extension.
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	// Byte counts of the optional header parts.
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	// Header byte count once the two fixed bytes are in.
	localparam logic [3:0] BASE_HDR_BYTES = 4'd2;

	// One byte request from the receive side.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} byte_item_t;

	// One decoded header result.
	typedef struct packed {
		logic [3:0]  opcode;
		logic [3:0]  flag_bits;
		logic        masked;
		logic [63:0] payload_length;
		logic [31:0] mask_key;
		logic [3:0]  header_length;
	} hdr_result_t;

endpackage

[hdl/wsfh_byte_if.sv]
// ============================================================================
// wsfh_byte_if
// Byte channel into the parser: one buffer byte and its final-byte flag.
// ============================================================================
interface wsfh_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

[hdl/wsfh_hdr_if.sv]
// ============================================================================
// wsfh_hdr_if
// Result channel out of the parser: the decoded frame header fields.
// ============================================================================
interface wsfh_hdr_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic [3:0]  flag_bits;
	logic        masked;
	logic [63:0] payload_length;
	logic [31:0] mask_key;
	logic [3:0]  header_length;

	modport source (output valid, output opcode, output flag_bits, output masked,
		output payload_length, output mask_key, output header_length, input ready);
	modport sink   (input valid, input opcode, input flag_bits, input masked,
		input payload_length, input mask_key, input header_length, output ready);
endinterface

[hdl/websocket_frame_header_parser.sv]
// ============================================================================
// websocket_frame_header_parser
// Decodes a WebSocket frame header from a byte stream, one result per buffer.
// ============================================================================
// Usage:
// byte_in carries the received buffer one byte per request, with last set on
// the buffer's final byte. header_out carries one decoded header per buffer:
// opcode, flag bits, mask bit, payload length, masking key and the header
// length (nonzero only when the header and its whole payload have arrived).
// Throughput is one byte per cycle; each byte passes an input register and a
// phase update in the parser. The result of a buffer is registered in the
// result register once its final byte has passed the input register and the
// result register is free. A result waiting in the result register does not
// stop the flow: bytes that are not final keep being accepted. Only a final
// byte waits in the input register until the receiver takes the previous
// result, and then byte_in.ready drops until it moves on.
// After reset (arst_n low) both registers are empty and the parser expects
// the first header byte of a new buffer; each final byte also restarts it.
// ============================================================================
module websocket_frame_header_parser (
	input  logic       clk,
	input  logic       arst_n,
	wsfh_byte_if.sink  byte_in,
	wsfh_hdr_if.source header_out
);
	import wsfh_pkg::*;

	logic        valid_s1;
	byte_item_t  item_s1;
	logic        fire;
	logic        free;
	hdr_result_t result;

	// The parser consumes a byte unless it is final and the result slot is full.
	assign fire = valid_s1 && (!item_s1.last || free);

	wsfh_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.fire     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	wsfh_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.result  (result)
	);

	wsfh_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire && item_s1.last),
		.result     (result),
		.free       (free),
		.header_out (header_out)
	);

	// No key is reported for a frame whose mask bit is clear.
	a_key_masked: assert property (@(posedge clk) disable iff (!arst_n)
		header_out.valid && !header_out.masked |-> header_out.mask_key == 32'd0)
		else $error("masking key reported for an unmasked frame");

endmodule

[hdl/wsfh_in_reg.sv]
// ============================================================================
// wsfh_in_reg
// Input register: holds one byte request until the parser consumes it.
// ============================================================================
module wsfh_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	wsfh_byte_if.sink           byte_in,
	input  logic                fire,
	output logic                valid_s1,
	output wsfh_pkg::byte_item_t item_s1
);
	import wsfh_pkg::*;

	// The register takes a new request when empty or when its byte is consumed.
	assign byte_in.ready = !valid_s1 || fire;

	// Valid flag of the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	// Payload of the input stage.
	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			item_s1.data_byte <= byte_in.data_byte;
			item_s1.last      <= byte_in.last;
		end
	end

	// A held byte that is not consumed stays in place.
	a_hold_unconsumed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(item_s1))
		else $error("input stage dropped or changed an unconsumed byte");

endmodule

[hdl/wsfh_parser.sv]
// ============================================================================
// wsfh_parser
// Header state machine: takes one byte per consumed request and forms the
// result for the buffer's final byte from the updated state.
// ============================================================================
module wsfh_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  wsfh_pkg::byte_item_t  item_s1,
	output wsfh_pkg::hdr_result_t result
);
	import wsfh_pkg::*;

	phase_t      phase_q, phase_n;
	logic [3:0]  byte_cnt_q, byte_cnt_n;
	logic [3:0]  opcode_q, opcode_n;
	logic [3:0]  flag_q, flag_n;
	logic        mask_q, mask_n;
	logic [6:0]  len_code_q, len_code_n;
	logic [63:0] len_accum_q, len_accum_n;
	logic [31:0] key_q, key_n;
	logic [3:0]  hdr_cnt_q, hdr_cnt_n;
	// Payload bytes still missing before the frame body is complete.
	logic [63:0] remain_q, remain_n;
	logic [7:0]  b;

	assign b = item_s1.data_byte;

	// Next-state logic: advance by one byte.
	always_comb begin
		phase_n     = phase_q;
		byte_cnt_n  = byte_cnt_q;
		opcode_n    = opcode_q;
		flag_n      = flag_q;
		mask_n      = mask_q;
		len_code_n  = len_code_q;
		len_accum_n = len_accum_q;
		key_n       = key_q;
		hdr_cnt_n   = hdr_cnt_q;
		unique case (phase_q) inside
			PH_FIRST: begin
				opcode_n  = b[3:0];
				flag_n    = b[7:4];
				hdr_cnt_n = 4'd1;
				phase_n   = PH_SECOND;
			end
			PH_SECOND: begin
				mask_n      = b[7];
				len_code_n  = b[6:0];
				hdr_cnt_n   = BASE_HDR_BYTES;
				byte_cnt_n  = '0;
				if (b[6:0] == LEN_CODE_EXT16) begin
					len_accum_n = '0;
					phase_n     = PH_EXT16;
				end else if (b[6:0] == LEN_CODE_EXT64) begin
					len_accum_n = '0;
					phase_n     = PH_EXT64;
				end else begin
					len_accum_n = {57'd0, b[6:0]};
					phase_n     = b[7] ? PH_KEY : PH_PAYLOAD;
				end
			end
			PH_EXT16, PH_EXT64: begin
				len_accum_n = {len_accum_q[55:0], b};
				hdr_cnt_n   = hdr_cnt_q + 4'd1;
				byte_cnt_n  = byte_cnt_q + 4'd1;
				if (byte_cnt_n >= ((phase_q == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
					phase_n    = mask_q ? PH_KEY : PH_PAYLOAD;
					byte_cnt_n = '0;
				end
			end
			PH_KEY: begin
				key_n      = {key_q[23:0], b};
				hdr_cnt_n  = hdr_cnt_q + 4'd1;
				byte_cnt_n = byte_cnt_q + 4'd1;
				if (byte_cnt_n >= KEY_BYTES) begin
					phase_n    = PH_PAYLOAD;
					byte_cnt_n = '0;
				end
			end
			default: begin
				phase_n = PH_PAYLOAD;
			end
		endcase

		// The remaining count tracks the length until the body starts, then
		// counts down once per body byte and rests at zero.
		if (phase_q == PH_PAYLOAD) begin
			remain_n = (remain_q == 64'd0) ? 64'd0 : remain_q - 64'd1;
		end else begin
			remain_n = len_accum_n;
		end
	end

	// Output logic: result fields from the updated state.
	always_comb begin
		result = '0;
		if (phase_n != PH_FIRST && phase_n != PH_SECOND) begin
			result.opcode    = opcode_n;
			result.flag_bits = flag_n;
			result.masked    = mask_n;
			case (phase_n) inside
				PH_EXT16, PH_EXT64: begin
					result.payload_length = {57'd0, len_code_n};
				end
				PH_KEY: begin
					result.payload_length = len_accum_n;
				end
				default: begin
					result.payload_length = len_accum_n;
					result.mask_key       = mask_n ? key_n : 32'd0;
					result.header_length  = (remain_n == 64'd0) ? hdr_cnt_n : 4'd0;
				end
			endcase
		end
	end

	// Control state; a final byte sends the parser back to the first phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			byte_cnt_q <= '0;
			hdr_cnt_q  <= '0;
			mask_q     <= 1'b0;
		end else if (fire) begin
			if (item_s1.last) begin
				phase_q    <= PH_FIRST;
				byte_cnt_q <= '0;
				hdr_cnt_q  <= '0;
				mask_q     <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				byte_cnt_q <= byte_cnt_n;
				hdr_cnt_q  <= hdr_cnt_n;
				mask_q     <= mask_n;
			end
		end
	end

	// Header data registers; each is written before it is read in a buffer.
	always_ff @(posedge clk) begin
		if (fire) begin
			opcode_q    <= opcode_n;
			flag_q      <= flag_n;
			len_code_q  <= len_code_n;
			len_accum_q <= len_accum_n;
			key_q       <= key_n;
			remain_q    <= remain_n;
		end
	end

	// A final byte always restarts parsing at the first header byte.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.last |=> phase_q == PH_FIRST && hdr_cnt_q == 4'd0)
		else $error("parser did not restart after the final byte");

	// A nonzero header length only comes with at least the two fixed bytes.
	a_hdr_len: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.header_length != 4'd0 |-> result.header_length >= BASE_HDR_BYTES)
		else $error("header length below the fixed header size");

endmodule

[hdl/wsfh_out_reg.sv]
// ============================================================================
// wsfh_out_reg
// Result register: holds one decoded header until the receiver takes it.
// ============================================================================
module wsfh_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  wsfh_pkg::hdr_result_t result,
	output logic                  free,
	wsfh_hdr_if.source            header_out
);
	import wsfh_pkg::*;

	logic        res_valid_q;
	hdr_result_t res_q;

	// The register can take a result when empty or being emptied this cycle.
	assign free = !res_valid_q || header_out.ready;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (free) begin
			res_valid_q <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= result;
		end
	end

	// Drive the result channel.
	assign header_out.valid          = res_valid_q;
	assign header_out.opcode         = res_q.opcode;
	assign header_out.flag_bits      = res_q.flag_bits;
	assign header_out.masked         = res_q.masked;
	assign header_out.payload_length = res_q.payload_length;
	assign header_out.mask_key       = res_q.mask_key;
	assign header_out.header_length  = res_q.header_length;

	// A new result never lands on one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result loaded over a pending result");

endmodule
